// ===== rtl/btlv_pkg.sv =====
`timescale 1ns / 1ps

package btlv_pkg;

  localparam int unsigned LenOctetsCap = 4;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_LEN_TOO_BIG = 2'd1,
    ST_TAG_OVF     = 2'd2
  } status_e;

  // one decoded header, as it travels from the parser to the output queue
  typedef struct packed {
    logic [1:0]  tag_class;
    logic        constructed;
    logic [31:0] tag_number;
    logic [31:0] content_length;
    logic [3:0]  header_size;
    status_e     status;
  } hdr_t;

endpackage

// ===== rtl/ber_tlv_header_decoder_top.sv =====
`timescale 1ns / 1ps
// Channel   Handshake          Payload
// input     push / full        data_byte_i, restart_i
// result    empty / pop        tag_class_o, constructed_o, tag_number_o,
//                              content_length_o, header_size_o, status_o
// config    cfg_we_i           cfg_data_i (max_length_octets)
//
// One byte per cycle while full is low; the parser updates its state in the cycle
// a byte is taken; a finished header enters the result queue with its last byte.
// full is high only while the result queue (QueueDepth entries) holds no free slot.
// Reset empties the queue, sets max_length_octets to 4 and expects an identifier.

module ber_tlv_header_decoder_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        restart_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  tag_class_o,
  output logic        constructed_o,
  output logic [31:0] tag_number_o,
  output logic [31:0] content_length_o,
  output logic [3:0]  header_size_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_data_i
);

  logic [2:0]     max_len_q;
  logic           accept;
  logic           emit;
  btlv_pkg::hdr_t hdr_in, hdr_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= 3'(btlv_pkg::LenOctetsCap);
    end else if (cfg_we_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  assign accept = push && !full;

  btlv_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .data_byte_i      (data_byte_i),
    .restart_i        (restart_i),
    .max_len_octets_i (max_len_q),
    .emit_o           (emit),
    .hdr_o            (hdr_in)
  );

  btlv_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept && emit),
    .wr_data_i (hdr_in),
    .rd_i      (pop),
    .rd_data_o (hdr_out),
    .full_o    (full),
    .empty_o   (empty)
  );

  assign tag_class_o      = hdr_out.tag_class;
  assign constructed_o    = hdr_out.constructed;
  assign tag_number_o     = hdr_out.tag_number;
  assign content_length_o = hdr_out.content_length;
  assign header_size_o    = hdr_out.header_size;
  assign status_o         = hdr_out.status;

endmodule

// ===== rtl/btlv_front.sv =====
`timescale 1ns / 1ps

module btlv_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       data_byte_i,
  input  logic             restart_i,
  input  logic [2:0]       max_len_octets_i,
  output logic             emit_o,
  output btlv_pkg::hdr_t   hdr_o
);

  typedef enum logic [1:0] {
    PH_IDENT   = 2'd0,
    PH_TAG     = 2'd1,
    PH_LENGTH  = 2'd2,
    PH_LENBYTE = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d, phase_cur;
  logic [1:0]  class_q, class_d;
  logic        cons_q, cons_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [2:0]  left_q, left_d;
  logic [3:0]  cnt_q, cnt_d, cnt_base;
  logic [2:0]  limit;
  logic [2:0]  left_dec;

  always_comb begin
    phase_cur = restart_i ? PH_IDENT : phase_q;
    cnt_base  = (phase_cur == PH_IDENT) ? 4'd0 : cnt_q;
    cnt_d     = (cnt_base != 4'd15) ? cnt_base + 4'd1 : cnt_base;
    limit     = (max_len_octets_i > 3'(btlv_pkg::LenOctetsCap)) ?
                3'(btlv_pkg::LenOctetsCap) : max_len_octets_i;
    left_dec  = (left_q != 3'd0) ? left_q - 3'd1 : left_q;

    phase_d = phase_cur;
    class_d = class_q;
    cons_d  = cons_q;
    tag_d   = tag_q;
    len_d   = len_q;
    left_d  = left_q;
    emit_o  = 1'b0;

    hdr_o.tag_class      = class_q;
    hdr_o.constructed    = cons_q;
    hdr_o.tag_number     = tag_q;
    hdr_o.content_length = 32'd0;
    hdr_o.header_size    = cnt_d;
    hdr_o.status         = btlv_pkg::ST_OK;

    case (phase_cur)
      PH_IDENT: begin
        class_d = data_byte_i[7:6];
        cons_d  = data_byte_i[5];
        len_d   = 32'd0;
        left_d  = 3'd0;
        if (data_byte_i[4:0] != 5'h1f) begin
          tag_d   = {27'd0, data_byte_i[4:0]};
          phase_d = PH_LENGTH;
        end else begin
          tag_d   = 32'd0;
          phase_d = PH_TAG;
        end
      end
      PH_TAG: begin
        // next shift would push bits out of the 32-bit tag
        if (tag_q[31:25] != 7'd0) begin
          emit_o           = 1'b1;
          hdr_o.tag_number = 32'd0;
          hdr_o.status     = btlv_pkg::ST_TAG_OVF;
        end else begin
          tag_d = {tag_q[24:0], data_byte_i[6:0]};
          if (!data_byte_i[7]) phase_d = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (!data_byte_i[7]) begin
          emit_o               = 1'b1;
          hdr_o.content_length = {24'd0, data_byte_i};
        end else if (data_byte_i[6:0] > {4'd0, limit}) begin
          emit_o       = 1'b1;
          hdr_o.status = btlv_pkg::ST_LEN_TOO_BIG;
        end else if (data_byte_i[6:0] == 7'd0) begin
          emit_o = 1'b1;
        end else begin
          len_d   = 32'd0;
          left_d  = data_byte_i[2:0];
          phase_d = PH_LENBYTE;
        end
      end
      PH_LENBYTE: begin
        len_d  = {len_q[23:0], data_byte_i};
        left_d = left_dec;
        if (left_dec == 3'd0) begin
          emit_o               = 1'b1;
          hdr_o.content_length = len_d;
        end
      end
      default: phase_d = PH_IDENT;
    endcase

    if (emit_o) begin
      phase_d = PH_IDENT;
      left_d  = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDENT;
      class_q <= 2'd0;
      cons_q  <= 1'b0;
      tag_q   <= 32'd0;
      len_q   <= 32'd0;
      left_q  <= 3'd0;
      cnt_q   <= 4'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      class_q <= class_d;
      cons_q  <= cons_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      left_q  <= left_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/btlv_queue.sv =====
`timescale 1ns / 1ps

module btlv_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  btlv_pkg::hdr_t wr_data_i,
  input  logic           rd_i,
  output btlv_pkg::hdr_t rd_data_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  btlv_pkg::hdr_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule
